// ===== rtl/core/ccd_pkg.sv =====
// ----------------------------------------------------------------------------
// ccd_pkg: shared types and constants of the concentric circle dedup block
// Holds the circle record, the per-cell control and status groups and the
// control state type.
// ----------------------------------------------------------------------------
package ccd_pkg;

  localparam int MAX_CIRCLES = 32;
  localparam int COORD_W     = 12;
  localparam int RADIUS_W    = 11;

  typedef struct packed {
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [RADIUS_W-1:0] r;
  } ccd_circle_t;

  typedef struct packed {
    logic        valid;
    logic        kept;
    ccd_circle_t circle;
  } ccd_entry_t;

  typedef struct packed {
    logic ins;
    logic shift;
    logic clear;
  } ccd_ctrl_t;

  typedef enum logic {
    CCD_COLLECT,
    CCD_DRAIN
  } ccd_state_t;

endpackage

// ===== rtl/core/ccd_in_if.sv =====
// ----------------------------------------------------------------------------
// ccd_in_if: candidate circle channel
// Valid/ready channel that carries one candidate circle per transfer.
// ----------------------------------------------------------------------------
interface ccd_in_if;
  logic                         valid;
  logic                         ready;
  logic [ccd_pkg::COORD_W-1:0]  center_x;
  logic [ccd_pkg::COORD_W-1:0]  center_y;
  logic [ccd_pkg::RADIUS_W-1:0] radius;
  logic                         last_circle;

  modport source (output valid, output center_x, output center_y, output radius,
                  output last_circle, input ready);
  modport sink (input valid, input center_x, input center_y, input radius,
                input last_circle, output ready);
endinterface

// ===== rtl/core/ccd_out_if.sv =====
// ----------------------------------------------------------------------------
// ccd_out_if: surviving circle channel
// Valid/ready channel that carries one surviving circle per transfer.
// ----------------------------------------------------------------------------
interface ccd_out_if;
  logic                         valid;
  logic                         ready;
  logic [ccd_pkg::COORD_W-1:0]  out_center_x;
  logic [ccd_pkg::COORD_W-1:0]  out_center_y;
  logic [ccd_pkg::RADIUS_W-1:0] out_radius;
  logic                         last_survivor;
  logic                         overflowed;

  modport source (output valid, output out_center_x, output out_center_y,
                  output out_radius, output last_survivor, output overflowed,
                  input ready);
  modport sink (input valid, input out_center_x, input out_center_y,
                input out_radius, input last_survivor, input overflowed,
                output ready);
endinterface

// ===== rtl/core/ccd_cell.sv =====
// ----------------------------------------------------------------------------
// ccd_cell: one entry of the circle chain
// Holds one stored circle, compares it with the arriving circle, takes the
// arriving circle when it is the first free cell, and takes its upper
// neighbor's entry when the chain shifts toward the output.
// ----------------------------------------------------------------------------
module ccd_cell (
  input  logic                clk,
  input  logic                rst,
  input  ccd_pkg::ccd_ctrl_t  ctrl,
  input  ccd_pkg::ccd_circle_t circle_in,
  input  logic                prev_valid,
  input  ccd_pkg::ccd_entry_t nbr,
  output ccd_pkg::ccd_entry_t entry,
  output logic                match,
  output logic                bigger
);

  logic free_first;

  assign free_first = !entry.valid && prev_valid;
  assign match  = entry.kept && (entry.circle.x == circle_in.x) &&
                  (entry.circle.y == circle_in.y);
  assign bigger = circle_in.r > entry.circle.r;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      entry.valid <= 1'b0;
      entry.kept  <= 1'b0;
    end else if (ctrl.shift) begin
      entry.valid <= nbr.valid;
      entry.kept  <= nbr.kept;
    end else if (ctrl.ins) begin
      if (free_first) begin
        entry.valid <= 1'b1;
        entry.kept  <= 1'b1;
      end else if (match) begin
        entry.kept <= 1'b0;
      end
    end
    if (ctrl.shift) begin
      entry.circle <= nbr.circle;
    end else if (ctrl.ins && free_first) begin
      entry.circle <= circle_in;
    end
  end

endmodule

// ===== rtl/core/concentric_circle_dedup.sv =====
// ----------------------------------------------------------------------------
// concentric_circle_dedup: keeps the largest circle of each exact center
// Candidate circles arrive on the circles channel, one per transfer, and the
// survivors of each list leave on the survivors channel in arrival order.
// While a list is collected the block takes one circle every cycle: each cell
// of the chain compares its stored circle with the arriving one in the same
// cycle. After the transfer of the circle marked last_circle the chain
// shifts toward the output one cell per cycle unless the receiver stalls,
// until no kept entry is left and the chain is cleared for the next list.
// Dropped entries ahead of the first survivor are shifted out before it is
// loaded into the output register. No circle is taken during the drain.
// The output register holds a survivor until it is taken; while the
// receiver stalls the chain holds at a kept entry. Circles that find the
// chain full are dropped and every survivor of that list carries overflowed.
// Synchronous reset empties the chain and the output register; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module concentric_circle_dedup (
  input  logic     clk,
  input  logic     rst,
  ccd_in_if.sink   circles,
  ccd_out_if.source survivors
);

  localparam int N = ccd_pkg::MAX_CIRCLES;

  ccd_pkg::ccd_state_t  state, state_next;
  ccd_pkg::ccd_ctrl_t   ctrl;
  ccd_pkg::ccd_circle_t circle_in;
  ccd_pkg::ccd_entry_t  entries [N];
  logic [N-1:0]         match_vec, bigger_vec, valid_vec, kept_vec;
  logic                 accept, found, larger, need_entry, full;
  logic                 ovf, ovf_next, load, any_kept, rest_kept;

  assign circle_in.x = circles.center_x;
  assign circle_in.y = circles.center_y;
  assign circle_in.r = circles.radius;

  for (genvar i = 0; i < N; i++) begin : g_cell
    ccd_pkg::ccd_entry_t nbr;
    logic                prev_valid;
    if (i == N - 1) begin : g_top
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = entries[i+1];
    end
    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_next
      assign prev_valid = entries[i-1].valid;
    end
    ccd_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .circle_in  (circle_in),
      .prev_valid (prev_valid),
      .nbr        (nbr),
      .entry      (entries[i]),
      .match      (match_vec[i]),
      .bigger     (bigger_vec[i])
    );
    assign valid_vec[i] = entries[i].valid;
    assign kept_vec[i]  = entries[i].kept;
  end

  assign accept     = circles.valid && circles.ready;
  assign found      = |match_vec;
  assign larger     = |(match_vec & bigger_vec);
  assign need_entry = !found || larger;
  assign full       = valid_vec[N-1];
  assign any_kept   = |kept_vec;
  assign rest_kept  = |kept_vec[N-1:1];

  always_comb begin
    state_next = state;
    case (state)
      ccd_pkg::CCD_COLLECT: begin
        if (accept && circles.last_circle) begin
          state_next = ccd_pkg::CCD_DRAIN;
        end
      end
      ccd_pkg::CCD_DRAIN: begin
        if (!any_kept) begin
          state_next = ccd_pkg::CCD_COLLECT;
        end
      end
      default: state_next = ccd_pkg::CCD_COLLECT;
    endcase
  end

  always_comb begin
    circles.ready = 1'b0;
    load          = 1'b0;
    ctrl          = '0;
    ovf_next      = ovf;
    case (state)
      ccd_pkg::CCD_COLLECT: begin
        circles.ready = 1'b1;
        ctrl.ins      = accept && need_entry && !full;
        if (accept && need_entry && full) begin
          ovf_next = 1'b1;
        end
      end
      ccd_pkg::CCD_DRAIN: begin
        if (!any_kept) begin
          ctrl.clear = 1'b1;
          ovf_next   = 1'b0;
        end else begin
          load       = entries[0].kept && (!survivors.valid || survivors.ready);
          ctrl.shift = !entries[0].kept || load;
        end
      end
      default: begin
        ctrl.clear = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ccd_pkg::CCD_COLLECT;
      ovf             <= 1'b0;
      survivors.valid <= 1'b0;
    end else begin
      state <= state_next;
      ovf   <= ovf_next;
      if (load) begin
        survivors.valid <= 1'b1;
      end else if (survivors.ready) begin
        survivors.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      survivors.out_center_x  <= entries[0].circle.x;
      survivors.out_center_y  <= entries[0].circle.y;
      survivors.out_radius    <= entries[0].circle.r;
      survivors.last_survivor <= !rest_kept;
      survivors.overflowed    <= ovf;
    end
  end

  a_kept_valid: assert property (@(posedge clk) disable iff (rst)
    (kept_vec & ~valid_vec) == '0)
    else $error("kept entry without a valid circle");

  a_one_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match_vec))
    else $error("two kept entries share a center");

  a_no_shift_collect: assert property (@(posedge clk) disable iff (rst)
    (state == ccd_pkg::CCD_COLLECT) |-> !ctrl.shift && !load)
    else $error("chain shifted while collecting");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (load && !rest_kept) |=> !any_kept)
    else $error("kept entry left after the final survivor");

endmodule
